[hdl/assert_macros.svh]
// assertion macros for the rtl files, included by cpg_gen_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/cpg_pkg.sv]
// types and constants of the crank and cam pattern generator
`default_nettype none

package cpg_pkg;

	localparam int unsigned ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_TEETH_TOTAL      = 3'd0,
		REG_TEETH_MISSING    = 3'd1,
		REG_HALF_TOOTH_LEN   = 3'd2,
		REG_GAP_POLARITY     = 3'd3,
		REG_CAM_POLARITY     = 3'd4,
		REG_CAM_WINDOWS_USED = 3'd5
	} cpg_reg_t;

	localparam logic [7:0]  TEETH_TOTAL_RST      = 8'd60;
	localparam logic [3:0]  TEETH_MISSING_RST    = 4'd2;
	localparam logic [11:0] HALF_TOOTH_LEN_RST   = 12'd6;
	localparam logic        GAP_POLARITY_RST     = 1'b1;
	localparam logic        CAM_POLARITY_RST     = 1'b0;
	localparam logic [4:0]  CAM_WINDOWS_USED_RST = 5'd10;

	typedef struct packed {
		logic [7:0]  teeth_total;
		logic [3:0]  teeth_missing;
		logic [11:0] half_tooth_len;
		logic        gap_polarity;
		logic        cam_polarity;
		logic [4:0]  cam_windows_used;
	} cpg_cfg_t;

	typedef struct packed {
		logic [11:0] wstart;
		logic [11:0] wend;
	} cpg_window_t;

endpackage

`default_nettype wire

[hdl/crank_cam_pattern_generator_unit.sv]
// a position request passes the sequencer stage and then the output register before its result appears
// throughput: one request per cycle while the result side does not stall, loads and positions alike, set by the
// single sequencer stage that reads the window table and updates the counters
// backpressure on the result side stalls the input once the output register and stage are full
// reset: asynchronous, clears the counters, valid flags and config registers to their defaults; the window table
// holds no defined contents until loaded
`default_nettype none

module crank_cam_pattern_generator_unit #(
	parameter int unsigned POSITIONS   = 1440,
	parameter int unsigned CAM_WINDOWS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// apb configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cpg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	// input stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [31:0]                s_tdata,  // window_index[3:0], window_start[15:4], window_end[27:16], zeros
	input  wire logic                       s_tuser,  // mode
	// output stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [15:0]                m_tdata,  // angle_position[11:0], crank_level[12], cam_level[13], zeros
	output logic                            m_tlast   // cycle_end
);
	import cpg_pkg::*;

	cpg_cfg_t    cfg;
	logic [11:0] out_position;
	logic        out_crank;
	logic        out_cam;

	cpg_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpg_gen_core #(
		.POSITIONS   (POSITIONS),
		.CAM_WINDOWS (CAM_WINDOWS)
	) u_gen_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_mode      (s_tuser),
		.in_index     (s_tdata[3:0]),
		.in_wstart    (s_tdata[15:4]),
		.in_wend      (s_tdata[27:16]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_position (out_position),
		.out_crank    (out_crank),
		.out_cam      (out_cam),
		.out_last     (m_tlast)
	);

	assign m_tdata = {2'b00, out_cam, out_crank, out_position};

endmodule

`default_nettype wire

[hdl/cpg_cfg_regs.sv]
// apb register file of the pattern generator
`default_nettype none

module cpg_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cpg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output cpg_pkg::cpg_cfg_t               cfg
);
	import cpg_pkg::*;

	cpg_cfg_t cfg_q;
	cpg_reg_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = cpg_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.teeth_total      <= TEETH_TOTAL_RST;
			cfg_q.teeth_missing    <= TEETH_MISSING_RST;
			cfg_q.half_tooth_len   <= HALF_TOOTH_LEN_RST;
			cfg_q.gap_polarity     <= GAP_POLARITY_RST;
			cfg_q.cam_polarity     <= CAM_POLARITY_RST;
			cfg_q.cam_windows_used <= CAM_WINDOWS_USED_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_TEETH_TOTAL:      cfg_q.teeth_total      <= pwdata[7:0];
				REG_TEETH_MISSING:    cfg_q.teeth_missing    <= pwdata[3:0];
				REG_HALF_TOOTH_LEN:   cfg_q.half_tooth_len   <= pwdata[11:0];
				REG_GAP_POLARITY:     cfg_q.gap_polarity     <= pwdata[0];
				REG_CAM_POLARITY:     cfg_q.cam_polarity     <= pwdata[0];
				REG_CAM_WINDOWS_USED: cfg_q.cam_windows_used <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_TEETH_TOTAL:      prdata = {24'd0, cfg_q.teeth_total};
			REG_TEETH_MISSING:    prdata = {28'd0, cfg_q.teeth_missing};
			REG_HALF_TOOTH_LEN:   prdata = {20'd0, cfg_q.half_tooth_len};
			REG_GAP_POLARITY:     prdata = {31'd0, cfg_q.gap_polarity};
			REG_CAM_POLARITY:     prdata = {31'd0, cfg_q.cam_polarity};
			REG_CAM_WINDOWS_USED: prdata = {27'd0, cfg_q.cam_windows_used};
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hdl/cpg_win_mem.sv]
// cam window table: one write port, two registered read ports
`default_nettype none

module cpg_win_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire cpg_pkg::cpg_window_t wr_data,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr0,
	input  wire logic [AW-1:0]        rd_addr1,
	output cpg_pkg::cpg_window_t      rd_data0,
	output cpg_pkg::cpg_window_t      rd_data1
);
	import cpg_pkg::*;

	cpg_window_t mem_q [DEPTH];
	cpg_window_t rd0_q;
	cpg_window_t rd1_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd0_q <= mem_q[rd_addr0];
			rd1_q <= mem_q[rd_addr1];
		end
	end

	assign rd_data0 = rd0_q;
	assign rd_data1 = rd1_q;

endmodule

`default_nettype wire

[hdl/cpg_gen_core.sv]
// crank and cam sequencer around the window table
`default_nettype none

`include "assert_macros.svh"

module cpg_gen_core #(
	parameter int unsigned POSITIONS   = 1440,
	parameter int unsigned CAM_WINDOWS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cpg_pkg::cpg_cfg_t cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_mode,
	input  wire logic [3:0]        in_index,
	input  wire logic [11:0]       in_wstart,
	input  wire logic [11:0]       in_wend,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [11:0]            out_position,
	output logic                   out_crank,
	output logic                   out_cam,
	output logic                   out_last
);
	import cpg_pkg::*;

	localparam int unsigned AW = (CAM_WINDOWS > 1) ? $clog2(CAM_WINDOWS) : 1;
	localparam int unsigned IW = $clog2(CAM_WINDOWS + 1);
	localparam logic [11:0]   LAST_POS = 12'(POSITIONS - 1);
	localparam logic [IW-1:0] WIN_MAX  = IW'(CAM_WINDOWS);

	// sequencer state
	logic [11:0]   position_q;
	logic [11:0]   half_phase_q;
	logic          half_parity_q;
	logic [7:0]    tooth_count_q;
	logic          crank_state_q;
	logic [IW-1:0] cam_index_q;

	logic        s1_valid_s1;
	logic        out_valid_q;
	logic [11:0] out_pos_q;
	logic        out_crank_q;
	logic        out_cam_q;
	logic        out_last_q;

	logic        accept;
	logic        s1_go;
	logic        s1_fire;
	logic        wr_en;
	cpg_window_t wr_data;
	cpg_window_t rd0;
	cpg_window_t rd1;
	cpg_window_t win;

	logic [IW-1:0] used;
	logic          step;
	logic [IW-1:0] idx_adv;
	logic [IW-1:0] idx_rd;
	logic [IW-1:0] idx_rd1;
	logic          in_window;
	logic          cam;

	logic        boundary;
	logic [8:0]  tooth_sum;
	logic        toggle;
	logic        crank_new;
	logic [7:0]  tooth_inc;
	logic [7:0]  tooth_next;
	logic [11:0] len;
	logic [11:0] phase_inc;
	logic        phase_wrap;
	logic        last;

	assign s1_go    = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid_s1 && s1_go;
	assign in_ready = !s1_valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	// loads go straight into the table at the request edge
	assign wr_en   = accept && in_mode && ({1'b0, in_index} < 5'(CAM_WINDOWS));
	assign wr_data = '{wstart: in_wstart, wend: in_wend};

	// cam scan over the current and the following window
	assign used      = (cfg.cam_windows_used > 5'(CAM_WINDOWS)) ? WIN_MAX
	                   : cfg.cam_windows_used[IW-1:0];
	assign step      = (cam_index_q < used) && (position_q >= rd0.wend);
	assign idx_adv   = cam_index_q + IW'(step);
	assign win       = step ? rd1 : rd0;
	assign in_window = (idx_adv < used) && (position_q >= win.wstart)
	                   && (position_q < win.wend);
	assign cam       = in_window ? cfg.cam_polarity : !cfg.cam_polarity;

	// crank wheel
	assign boundary   = (half_phase_q == 12'd0);
	assign tooth_sum  = {1'b0, tooth_count_q} + {5'd0, cfg.teeth_missing};
	assign toggle     = boundary && (position_q != 12'd0) && (tooth_sum < {1'b0, cfg.teeth_total});
	assign crank_new  = crank_state_q ^ toggle;
	assign tooth_inc  = tooth_count_q + 8'd1;
	assign tooth_next = (boundary && !half_parity_q)
	                    ? ((tooth_inc >= cfg.teeth_total) ? 8'd0 : tooth_inc)
	                    : tooth_count_q;
	assign len        = (cfg.half_tooth_len == 12'd0) ? 12'd1 : cfg.half_tooth_len;
	assign phase_inc  = half_phase_q + 12'd1;
	assign phase_wrap = (phase_inc >= len);
	assign last       = (position_q >= LAST_POS);

	// prefetch the windows that the next position will look at
	always_comb begin
		if (s1_valid_s1) begin
			idx_rd = last ? '0 : idx_adv;
		end else begin
			idx_rd = cam_index_q;
		end
		idx_rd1 = idx_rd + IW'(1);
	end

	cpg_win_mem #(
		.DEPTH (CAM_WINDOWS),
		.AW    (AW)
	) u_win_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (in_index[AW-1:0]),
		.wr_data  (wr_data),
		.rd_en    (accept && !in_mode),
		.rd_addr0 (idx_rd[AW-1:0]),
		.rd_addr1 (idx_rd1[AW-1:0]),
		.rd_data0 (rd0),
		.rd_data1 (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= accept && !in_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			half_phase_q  <= '0;
			half_parity_q <= 1'b0;
			tooth_count_q <= '0;
			crank_state_q <= !GAP_POLARITY_RST;
			cam_index_q   <= '0;
		end else if (s1_fire) begin
			if (last) begin
				position_q    <= '0;
				half_phase_q  <= '0;
				half_parity_q <= 1'b0;
				tooth_count_q <= '0;
				crank_state_q <= !cfg.gap_polarity;
				cam_index_q   <= '0;
			end else begin
				position_q    <= position_q + 12'd1;
				half_phase_q  <= phase_wrap ? 12'd0 : phase_inc;
				half_parity_q <= half_parity_q ^ phase_wrap;
				tooth_count_q <= tooth_next;
				crank_state_q <= crank_new;
				cam_index_q   <= idx_adv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_pos_q   <= position_q;
			out_crank_q <= crank_new;
			out_cam_q   <= cam;
			out_last_q  <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;
	assign out_crank    = out_crank_q;
	assign out_cam      = out_cam_q;
	assign out_last     = out_last_q;

	`ASSERT_ALWAYS(a_cam_index_range, clk, arst_n, cam_index_q <= WIN_MAX)
	`ASSERT_ALWAYS(a_position_range, clk, arst_n, position_q <= LAST_POS)
	`ASSERT_NEXT(a_cycle_restart, clk, arst_n, s1_fire && last, position_q == 12'd0 && cam_index_q == '0)
	`ASSERT_NEXT(a_crank_steady, clk, arst_n, s1_fire && !last && !boundary, crank_state_q == $past(crank_state_q))

endmodule

`default_nettype wire
